FILE: rtl/abr_pkg.sv
package abr_pkg;

	localparam int MAX_PAYLOAD_DEF = 30;

	localparam logic [7:0] ACK_LEN  = 8'h03;
	localparam logic [7:0] ACK_MARK = 8'h41;
	localparam logic [7:0] SEQ_ZERO = 8'h30;

	localparam logic [1:0] ST_NEW  = 2'd0;
	localparam logic [1:0] ST_DUP  = 2'd1;
	localparam logic [1:0] ST_BAD  = 2'd2;

	localparam logic [1:0] ACK_IDX_LAST = 2'd3;

	typedef struct packed {
		logic       take_byte;  // input beat accepted
		logic       decide;     // clear counters, rewind read pointer, latch status
		logic       deliver;    // packet accepted: flip expected sequence
		logic [1:0] status;
		logic       out_load;
		logic       out_sel_ack;
	} abr_cmd_t;

	typedef struct packed {
		logic good;
		logic seq_exp;
		logic seq_valid;
		logic acked_once;
		logic plen_zero;
		logic pay_last;
		logic ack_last;
		logic out_free;
	} abr_sts_t;

	function automatic logic [7:0] ack_byte(input logic [1:0] idx, input logic seq);
		logic [7:0] seqc;
		seqc = SEQ_ZERO | {7'd0, seq};
		case (idx)
			2'd0:    ack_byte = ACK_LEN;
			2'd1:    ack_byte = seqc;
			2'd2:    ack_byte = ACK_MARK;
			default: ack_byte = ~(ACK_LEN + seqc + ACK_MARK);
		endcase
	endfunction

endpackage

FILE: rtl/alternating_bit_receiver.sv
// Alternating-bit receiver.
// Input channel (in_valid/in_stall): one packet byte per beat on pkt_byte, with
// pkt_end high on the final (checksum) byte. Byte 0 is a length byte, byte 1
// the sequence character, the rest payload. Bytes past MAX_PAYLOAD+3 are dropped.
// Output channel (out_valid/out_stall): one byte per beat; out_kind 0 for a
// payload byte, 1 for an ACK byte, pkt_status per packet, out_end on the last.
// Bytes are taken one per cycle while a packet comes in. After the end beat the
// block checks the packet in a decide state; an accepted packet then gives its
// payload bytes and the 4-byte ACK, a rejected one a resent ACK, or nothing before
// the first acceptance. Bytes go out one per cycle while out_stall is low, each
// through the output register. in_stall drops after the decision if nothing is sent.
// in_stall is high from the end beat until the last ACK byte sits in the output
// register, so the next packet may start while that byte still waits.
// A stalled output holds its byte; the burst simply pauses.
// Reset: waits for sequence '0', no ACK to resend, output empty.
module alternating_bit_receiver import abr_pkg::*; #(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] pkt_byte,
	input  logic       pkt_end,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       out_kind,
	output logic [1:0] pkt_status,
	output logic       out_end
);

	abr_cmd_t cmd;
	abr_sts_t sts;

	abr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.pkt_end  (pkt_end),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	abr_dp #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.pkt_byte   (pkt_byte),
		.cmd        (cmd),
		.sts        (sts),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.out_byte   (out_byte),
		.out_kind   (out_kind),
		.pkt_status (pkt_status),
		.out_end    (out_end)
	);

endmodule

FILE: rtl/abr_ctrl.sv
module abr_ctrl import abr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     pkt_end,
	output logic     in_stall,
	input  abr_sts_t sts,
	output abr_cmd_t cmd
);

	localparam logic [1:0] S_RECV   = 2'd0;
	localparam logic [1:0] S_DECIDE = 2'd1;
	localparam logic [1:0] S_PAY    = 2'd2;
	localparam logic [1:0] S_ACK    = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign in_stall = (state_q != S_RECV);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_d         = state_q;
		cmd             = '0;
		cmd.take_byte   = accept;
		case (state_q)
			S_RECV: begin
				if (accept && pkt_end) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				if (sts.good && sts.seq_exp) begin
					cmd.deliver = 1'b1;
					cmd.status  = ST_NEW;
					state_d     = sts.plen_zero ? S_ACK : S_PAY;
				end else begin
					cmd.status = (sts.good && sts.seq_valid) ? ST_DUP : ST_BAD;
					// nothing to resend before the first accepted packet
					state_d    = sts.acked_once ? S_ACK : S_RECV;
				end
			end
			S_PAY: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					if (sts.pay_last) state_d = S_ACK;
				end
			end
			S_ACK: begin
				if (sts.out_free) begin
					cmd.out_load    = 1'b1;
					cmd.out_sel_ack = 1'b1;
					if (sts.ack_last) state_d = S_RECV;
				end
			end
			default: state_d = S_RECV;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_RECV;
		else state_q <= state_d;
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("output register overwritten while stalled");

	a_end_decide: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && pkt_end) |=> (state_q == S_DECIDE))
		else $error("final beat not followed by decision");

	a_decide_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE) |=> (state_q != S_DECIDE))
		else $error("decision lasted more than one cycle");

	a_ack_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ACK && cmd.out_load && sts.ack_last) |=> (state_q == S_RECV))
		else $error("ACK burst did not finish");

endmodule

FILE: rtl/abr_dp.sv
module abr_dp import abr_pkg::*; #(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] pkt_byte,
	input  abr_cmd_t   cmd,
	output abr_sts_t   sts,
	input  logic       out_stall,
	output logic       out_valid,
	output logic [7:0] out_byte,
	output logic       out_kind,
	output logic [1:0] pkt_status,
	output logic       out_end
);

	localparam int DEPTH  = MAX_PAYLOAD + 1;
	localparam int CNT_W  = $clog2(MAX_PAYLOAD + 4);
	localparam int ADDR_W = $clog2(MAX_PAYLOAD + 1);
	localparam logic [CNT_W-1:0] KEEP_LIMIT = CNT_W'(MAX_PAYLOAD + 3);

	logic [CNT_W-1:0]  cnt_q;
	logic [7:0]        sum_q;
	logic [7:0]        seq_byte_q;
	logic              exp_seq_q;
	logic              acked_q;
	logic              last_ack_q;
	logic [1:0]        status_q;
	logic [ADDR_W-1:0] plen_q;
	logic [ADDR_W-1:0] ptr_q;
	logic [ADDR_W-1:0] ptr_d;
	logic [1:0]        ack_idx_q;
	logic [7:0]        mem [DEPTH];
	logic [7:0]        rd_data_q;
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic              out_kind_q;
	logic [1:0]        out_status_q;
	logic              out_end_q;

	logic              keep;
	logic [CNT_W-1:0]  wr_off;
	logic [CNT_W-1:0]  plen_full;
	logic [7:0]        sum_chk;
	logic [7:0]        exp_char;

	assign keep      = cnt_q < KEEP_LIMIT;
	assign wr_off    = cnt_q - CNT_W'(2);
	assign plen_full = cnt_q - CNT_W'(3);
	assign sum_chk   = sum_q + 8'(cnt_q) - 8'd1;
	assign exp_char  = SEQ_ZERO | {7'd0, exp_seq_q};

	always_comb begin
		sts.good       = (cnt_q >= CNT_W'(3)) && (sum_chk == 8'hFF);
		sts.seq_exp    = (seq_byte_q == exp_char);
		sts.seq_valid  = (seq_byte_q == SEQ_ZERO) || (seq_byte_q == (SEQ_ZERO | 8'd1));
		sts.acked_once = acked_q;
		sts.plen_zero  = (plen_full == '0);
		sts.pay_last   = ((ptr_q + ADDR_W'(1)) == plen_q);
		sts.ack_last   = (ack_idx_q == ACK_IDX_LAST);
		sts.out_free   = !out_valid_q || !out_stall;
	end

	always_comb begin
		ptr_d = ptr_q;
		if (cmd.decide) ptr_d = '0;
		else if (cmd.out_load && !cmd.out_sel_ack) ptr_d = ptr_q + ADDR_W'(1);
	end

	// payload store, read address runs one step ahead so data is ready on load
	always_ff @(posedge clk) begin
		if (cmd.take_byte && keep && cnt_q >= CNT_W'(2)) mem[wr_off[ADDR_W-1:0]] <= pkt_byte;
		rd_data_q <= mem[ptr_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			sum_q      <= '0;
			seq_byte_q <= '0;
			exp_seq_q  <= 1'b0;
			acked_q    <= 1'b0;
			last_ack_q <= 1'b0;
			status_q   <= ST_NEW;
			plen_q     <= '0;
			ptr_q      <= '0;
			ack_idx_q  <= '0;
		end else begin
			ptr_q <= ptr_d;
			if (cmd.take_byte && keep) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(1)) seq_byte_q <= pkt_byte;
				if (cnt_q != '0) sum_q <= sum_q + pkt_byte;
			end
			if (cmd.decide) begin
				cnt_q     <= '0;
				sum_q     <= '0;
				status_q  <= cmd.status;
				plen_q    <= plen_full[ADDR_W-1:0];
				ack_idx_q <= '0;
			end
			if (cmd.deliver) begin
				last_ack_q <= exp_seq_q;
				acked_q    <= 1'b1;
				exp_seq_q  <= ~exp_seq_q;
			end
			if (cmd.out_load && cmd.out_sel_ack) ack_idx_q <= ack_idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else out_valid_q <= cmd.out_load || (out_valid_q && out_stall);
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q <= status_q;
			out_kind_q   <= cmd.out_sel_ack;
			if (cmd.out_sel_ack) begin
				out_byte_q <= ack_byte(ack_idx_q, last_ack_q);
				out_end_q  <= (ack_idx_q == ACK_IDX_LAST);
			end else begin
				out_byte_q <= rd_data_q;
				out_end_q  <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign out_kind   = out_kind_q;
	assign pkt_status = out_status_q;
	assign out_end    = out_end_q;

endmodule

FILE: tb/sv/alternating_bit_receiver_tb.sv
`timescale 1ns / 100ps

module alternating_bit_receiver_tb;
	import abr_pkg::*;

	localparam int KEEP_BYTES  = MAX_PAYLOAD_DEF + 3;
	localparam int STORE_N     = MAX_PAYLOAD_DEF + 1;
	localparam int RAND_BEATS  = 160;
	localparam int HOLD_CYCLES = 150;
	localparam int IDLE_LIMIT  = 2000;
	localparam int TAIL_CYCLES = 40;
	localparam int NO_CHECK    = -1;

	typedef enum int {FILL_RAND, FILL_ZERO, FILL_ONES} fill_t;

	typedef struct packed {
		logic [7:0] data;
		logic       kind;
		logic [1:0] status;
		logic       last;
	} out_beat_t;

	typedef struct {
		logic [7:0] seqc;
		int         total;
		fill_t      fill;
		bit         corrupt;
		int         want_n;
		int         want_st;
	} dir_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] pkt_byte = 8'd0;
	logic       pkt_end = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       out_kind;
	logic [1:0] pkt_status;
	logic       out_end;

	alternating_bit_receiver dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.pkt_byte   (pkt_byte),
		.pkt_end    (pkt_end),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.out_kind   (out_kind),
		.pkt_status (pkt_status),
		.out_end    (out_end)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// receiver-side copy of the protocol state
	logic       rx_exp_seq = 1'b0;
	logic       rx_acked = 1'b0;
	logic       rx_ack_seq = 1'b0;
	int         rx_count = 0;
	logic [7:0] rx_sum = 8'd0;
	logic [7:0] rx_seq = 8'd0;
	logic [7:0] rx_store [STORE_N];

	out_beat_t  pending_out [$];
	int         pushed_n = 0;
	logic [1:0] last_status = ST_NEW;
	int         fail_cnt = 0;
	int         beats_sent = 0;
	int         send_idle_pct = 0;
	int         stall_pct = 0;
	bit         hold_req = 1'b0;
	int         hold_left = 0;
	int         idle_cycles = 0;

	task automatic report(input string msg);
		fail_cnt++;
		if (fail_cnt <= 10)
			$display("mismatch @%0t: %s", $time, msg);
	endtask

	task automatic push_out(input logic [7:0] d, input logic k, input logic [1:0] st,
			input logic l);
		out_beat_t e;
		e = '{data: d, kind: k, status: st, last: l};
		pending_out.push_back(e);
		pushed_n++;
		last_status = st;
	endtask

	task automatic push_ack(input logic [7:0] seqc, input logic [1:0] st);
		logic [7:0] ck;
		ck = ~(ACK_LEN + seqc + ACK_MARK);
		push_out(ACK_LEN, 1'b1, st, 1'b0);
		push_out(seqc, 1'b1, st, 1'b0);
		push_out(ACK_MARK, 1'b1, st, 1'b0);
		push_out(ck, 1'b1, st, 1'b1);
	endtask

	task automatic predict_delivery(input logic [7:0] b, input logic e);
		int n;
		int i;
		logic [7:0] chk;
		logic [7:0] expc;
		logic good;
		logic [1:0] st;
		if (rx_count < KEEP_BYTES) begin
			if (rx_count == 1)
				rx_seq = b;
			if (rx_count >= 1)
				rx_sum = rx_sum + b;
			if (rx_count >= 2)
				rx_store[rx_count - 2] = b;
			rx_count++;
		end
		if (!e)
			return;
		n = rx_count;
		chk = rx_sum + 8'(n - 1);
		rx_count = 0;
		rx_sum = 8'd0;
		good = (n >= 3) && (chk == 8'hFF);
		expc = SEQ_ZERO | {7'd0, rx_exp_seq};
		if (good && rx_seq == expc) begin
			for (i = 0; i < n - 3; i++)
				push_out(rx_store[i], 1'b0, ST_NEW, 1'b0);
			push_ack(expc, ST_NEW);
			rx_ack_seq = rx_exp_seq;
			rx_acked = 1'b1;
			rx_exp_seq = ~rx_exp_seq;
		end else begin
			st = (good && (rx_seq == SEQ_ZERO || rx_seq == (SEQ_ZERO | 8'd1))) ? ST_DUP : ST_BAD;
			if (rx_acked)
				push_ack(SEQ_ZERO | {7'd0, rx_ack_seq}, st);
		end
	endtask

	// called just after a falling edge; returns just after a falling edge once the beat is taken
	task automatic send_beat(input logic [7:0] b, input logic e);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		pkt_byte <= b;
		pkt_end  <= e;
		do @(posedge clk); while (in_stall);
		predict_delivery(b, e);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic send_packet(input logic [7:0] seqc, input int total, input fill_t fill,
			input bit corrupt);
		logic [7:0] pk [64];
		logic [7:0] s;
		int kept;
		int i;
		kept = (total < KEEP_BYTES) ? total : KEEP_BYTES;
		for (i = 0; i < total; i++) begin
			case (fill)
				FILL_ZERO: pk[i] = 8'h00;
				FILL_ONES: pk[i] = 8'hFF;
				default:   pk[i] = 8'($urandom_range(255));
			endcase
		end
		if (total >= 2)
			pk[1] = seqc;
		// checksum sits on the last kept byte; anything after it is dropped
		if (total >= 3) begin
			s = 8'(kept - 1);
			for (i = 1; i < kept - 1; i++)
				s = s + pk[i];
			pk[kept - 1] = 8'hFF - s;
			if (corrupt)
				pk[kept - 1] = pk[kept - 1] ^ 8'($urandom_range(1, 255));
		end
		for (i = 0; i < total; i++)
			send_beat(pk[i], i == total - 1);
	endtask

	task automatic rand_packet();
		int r;
		int tot;
		logic [7:0] sq;
		r = $urandom_range(99);
		tot = ($urandom_range(3) != 0) ? $urandom_range(3, 10) : $urandom_range(3, KEEP_BYTES);
		sq = SEQ_ZERO | {7'd0, rx_exp_seq};
		if (r < 60)
			send_packet(sq, tot, FILL_RAND, 1'b0);
		else if (r < 70)
			send_packet(sq ^ 8'h01, tot, FILL_RAND, 1'b0);
		else if (r < 82)
			send_packet(SEQ_ZERO | 8'($urandom_range(1)), tot, FILL_RAND, 1'b1);
		else if (r < 88)
			send_packet(sq, $urandom_range(1, 2), FILL_RAND, 1'b0);
		else if (r < 94)
			send_packet(8'($urandom_range(255)), tot, FILL_RAND, 1'b0);
		else
			send_packet(sq, $urandom_range(KEEP_BYTES + 1, KEEP_BYTES + 8), FILL_RAND, 1'b0);
	endtask

	task automatic drain_out();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_out.size() != 0)
			@(negedge clk);
	endtask

	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin : check_out
		out_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_out.size() == 0) begin
				report($sformatf("unexpected beat byte %h kind %0d status %0d end %0d",
					out_byte, out_kind, pkt_status, out_end));
			end else begin
				want = pending_out.pop_front();
				if (want.data !== out_byte || want.kind !== out_kind ||
						want.status !== pkt_status || want.last !== out_end)
					report($sformatf("exp byte %h kind %0d status %0d end %0d, got %h %0d %0d %0d",
						want.data, want.kind, want.status, want.last,
						out_byte, out_kind, pkt_status, out_end));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		dir_row_t rows [13];
		int i;
		int ph;
		int nph;
		int base;
		int prior_n;

		rows = '{
			// rejected before any acceptance: nothing comes out
			'{SEQ_ZERO | 8'd1, 3, FILL_RAND, 1'b0, 0, NO_CHECK},
			'{SEQ_ZERO, 1, FILL_RAND, 1'b0, 0, NO_CHECK},
			// empty payload: ACK only
			'{SEQ_ZERO, 3, FILL_RAND, 1'b0, 4, ST_NEW},
			'{SEQ_ZERO, 8, FILL_ZERO, 1'b0, 4, ST_DUP},
			'{SEQ_ZERO | 8'd1, 6, FILL_ONES, 1'b1, 4, ST_BAD},
			'{8'h00, 5, FILL_RAND, 1'b0, 4, ST_BAD},
			'{8'hFF, 5, FILL_RAND, 1'b0, 4, ST_BAD},
			'{SEQ_ZERO | 8'd1, 2, FILL_RAND, 1'b0, 4, ST_BAD},
			'{SEQ_ZERO | 8'd1, KEEP_BYTES, FILL_ONES, 1'b0, 34, ST_NEW},
			// overlong: tail bytes dropped
			'{SEQ_ZERO, KEEP_BYTES + 7, FILL_RAND, 1'b0, 34, ST_NEW},
			'{SEQ_ZERO | 8'd1, KEEP_BYTES + 1, FILL_ZERO, 1'b0, 34, ST_NEW},
			'{SEQ_ZERO | 8'd1, 4, FILL_RAND, 1'b0, 4, ST_DUP},
			'{SEQ_ZERO, 4, FILL_RAND, 1'b0, 5, ST_NEW}
		};

		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		for (i = 0; i < 13; i++) begin
			prior_n = pushed_n;
			send_packet(rows[i].seqc, rows[i].total, rows[i].fill, rows[i].corrupt);
			if (rows[i].want_n != NO_CHECK && pushed_n - prior_n != rows[i].want_n)
				report($sformatf("row %0d: exp %0d beats, predicted %0d",
					i, rows[i].want_n, pushed_n - prior_n));
			if (rows[i].want_st != NO_CHECK && rows[i].want_n > 0 &&
					last_status != rows[i].want_st)
				report($sformatf("row %0d: exp status %0d, predicted %0d",
					i, rows[i].want_st, last_status));
		end
		drain_out();

		// long output hold-off while packets keep coming, so the input backs up
		hold_req = 1'b1;
		ph = 0;
		base = beats_sent;
		while (beats_sent - base < RAND_BEATS) begin
			nph = (beats_sent - base) * 4 / RAND_BEATS;
			if (nph != ph) begin
				drain_out();
				ph = nph;
				case (ph)
					1:       begin send_idle_pct = 73; stall_pct = 0;  end
					2:       begin send_idle_pct = 0;  stall_pct = 73; end
					default: begin send_idle_pct = 27; stall_pct = 27; end
				endcase
			end
			rand_packet();
		end

		drain_out();
		repeat (TAIL_CYCLES) @(negedge clk);
		fail_cnt = fail_cnt + pending_out.size();
		if (fail_cnt == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/abr_pkg.sv
rtl/abr_ctrl.sv
rtl/abr_dp.sv
rtl/alternating_bit_receiver.sv
tb/sv/alternating_bit_receiver_tb.sv
